@@ hw/rtl/sukt_pkg.sv @@
// Shared types, widths and codes for the sorted unique key table.
// Used by the interfaces, the slot cell, the core and the checker; no dependencies.
package sukt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_W       = 34;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Control sent from the core to every slot cell.
    typedef struct packed {
        logic cmp;   // capture compare flags against the incoming key
        logic ins;   // apply an insert shift
        logic rem;   // apply a remove shift
    } cell_ctrl_t;

    // Binary index of the single set bit of a one-hot vector.
    function automatic logic [SLOT_W-1:0] onehot_index(input logic [TABLE_DEPTH-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (v[i])
            begin
                r = r | SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/sukt_req_if.sv @@
// Request channel of the sorted unique key table: valid/ready plus op and key.
// Depends on sukt_pkg.
interface sukt_req_if;
    logic                          valid;
    logic                          ready;
    logic [sukt_pkg::OP_W-1:0]     op;
    logic [sukt_pkg::KEY_W-1:0]    key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

@@ hw/rtl/sukt_rsp_if.sv @@
// Response channel of the sorted unique key table: valid/ready plus status,
// position and entry count. Depends on sukt_pkg.
interface sukt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sukt_pkg::STATUS_W-1:0] status;
    logic [sukt_pkg::SLOT_W-1:0]   position;
    logic [sukt_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

@@ hw/rtl/sukt_cell.sv @@
// One slot of the key table: holds a key, compares it against a request and
// shifts toward its neighbors on insert or remove. Depends on sukt_pkg.
module sukt_cell (
    input  logic                        clk,
    input  sukt_pkg::cell_ctrl_t        ctrl,
    input  logic                        occupied,
    input  logic [sukt_pkg::KEY_W-1:0]  cmp_key,
    input  logic [sukt_pkg::KEY_W-1:0]  new_key,
    input  logic [sukt_pkg::KEY_W-1:0]  prev_key,
    input  logic                        prev_ge,
    input  logic [sukt_pkg::KEY_W-1:0]  next_key,
    output logic [sukt_pkg::KEY_W-1:0]  key_out,
    output logic                        ge,
    output logic                        eq
);

    logic [sukt_pkg::KEY_W-1:0] key_reg;
    logic                       ge_reg;
    logic                       eq_reg;

    // ge marks the slots at or past the request key's ordered place; an empty
    // slot always counts as past it.
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp)
        begin
            ge_reg <= !occupied || (cmp_key >= key_reg);
            eq_reg <= occupied && (cmp_key == key_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins && ge_reg)
        begin
            key_reg <= prev_ge ? prev_key : new_key;
        end
        else if (ctrl.rem && ge_reg)
        begin
            key_reg <= next_key;
        end
    end

    assign key_out = key_reg;
    assign ge      = ge_reg;
    assign eq      = eq_reg;

endmodule

@@ hw/rtl/sorted_unique_key_table_core.sv @@
// Sorted unique key table: a row of slot cells keeping keys in descending order.
// Depends on sukt_pkg, sukt_req_if, sukt_rsp_if and sukt_cell.
//
// Usage:
//   req carries one request word (op, key); rsp returns one word per request
//   with status, position and the entry count after the request.
//   Ops: insert, remove, search, clear. Status: done or found, duplicate,
//   not found, table full (duplicate is reported before full).
// Sequence:
//   A request is taken when req.valid and req.ready are high. At that same
//   edge every slot cell registers its compare against the request key in
//   parallel; when the request retires, the flags are reduced, the cells
//   shift, and the response word is registered, which raises rsp.valid. The
//   core takes no new request until the current one retires.
// Stall:
//   A valid response word holds while rsp.ready is low; a request already
//   compared waits in the cells, and req.ready stays low until it retires.
// Reset:
//   rst_n clears the entry count and all handshake state; the slot keys are
//   not reset and need no clearing pass, since only held slots are ever read.
module sorted_unique_key_table_core (
    input  logic         clk,
    input  logic         rst_n,
    sukt_req_if.sink     req,
    sukt_rsp_if.source   rsp
);

    localparam int DEPTH = sukt_pkg::TABLE_DEPTH;

    logic                            busy_reg;
    logic [sukt_pkg::OP_W-1:0]       op_reg;
    logic [sukt_pkg::KEY_W-1:0]      key_reg;
    logic [sukt_pkg::COUNT_W-1:0]    count_reg;
    logic [sukt_pkg::COUNT_W-1:0]    count_next;

    logic                            out_valid_reg;
    logic [sukt_pkg::STATUS_W-1:0]   status_reg;
    logic [sukt_pkg::STATUS_W-1:0]   status_next;
    logic [sukt_pkg::SLOT_W-1:0]     position_reg;
    logic [sukt_pkg::SLOT_W-1:0]     position_next;
    logic [sukt_pkg::COUNT_W-1:0]    out_count_reg;

    logic                            accept;
    logic                            retire;
    logic                            do_ins;
    logic                            do_rem;
    sukt_pkg::cell_ctrl_t            ctrl;

    logic [sukt_pkg::KEY_W-1:0]      slot_key [DEPTH];
    logic [DEPTH-1:0]                ge_vec;
    logic [DEPTH-1:0]                eq_vec;
    logic [DEPTH-1:0]                boundary;
    logic                            hit;
    logic                            full;

    // Plain copies of the port signals for the bound checker.
    logic                            req_valid;
    logic                            req_ready;
    logic                            rsp_valid;
    logic                            rsp_ready;
    logic [sukt_pkg::STATUS_W-1:0]   rsp_status;
    logic [sukt_pkg::SLOT_W-1:0]     rsp_position;
    logic [sukt_pkg::COUNT_W-1:0]    rsp_entry_count;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign retire    = busy_reg && (!out_valid_reg || rsp.ready);

    assign ctrl.cmp = accept;
    assign ctrl.ins = retire && do_ins;
    assign ctrl.rem = retire && do_rem;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_slot
            logic [sukt_pkg::KEY_W-1:0] prev_k;
            logic                       prev_g;
            logic [sukt_pkg::KEY_W-1:0] next_k;

            if (g == 0)
            begin : g_first
                assign prev_k = slot_key[0];
                assign prev_g = 1'b0;
            end
            else
            begin : g_inner
                assign prev_k = slot_key[g-1];
                assign prev_g = ge_vec[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign next_k = slot_key[g];
            end
            else
            begin : g_mid
                assign next_k = slot_key[g+1];
            end

            // Boundary of the insert: first slot at or past the key's place.
            assign boundary[g] = ge_vec[g] && !prev_g;

            sukt_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .occupied (sukt_pkg::COUNT_W'(g) < count_reg),
                .cmp_key  (req.key),
                .new_key  (key_reg),
                .prev_key (prev_k),
                .prev_ge  (prev_g),
                .next_key (next_k),
                .key_out  (slot_key[g]),
                .ge       (ge_vec[g]),
                .eq       (eq_vec[g])
            );
        end
    endgenerate

    assign hit  = |eq_vec;
    assign full = (count_reg == sukt_pkg::COUNT_W'(DEPTH));

    always_comb
    begin
        status_next   = sukt_pkg::ST_DONE;
        position_next = '0;
        count_next    = count_reg;
        do_ins        = 1'b0;
        do_rem        = 1'b0;
        unique case (op_reg)
            sukt_pkg::OP_INSERT:
            begin
                if (hit)
                begin
                    status_next = sukt_pkg::ST_DUP;
                end
                else if (full)
                begin
                    status_next = sukt_pkg::ST_FULL;
                end
                else
                begin
                    position_next = sukt_pkg::onehot_index(boundary);
                    count_next    = count_reg + sukt_pkg::COUNT_W'(1);
                    do_ins        = 1'b1;
                end
            end
            sukt_pkg::OP_REMOVE:
            begin
                if (hit)
                begin
                    position_next = sukt_pkg::onehot_index(eq_vec);
                    count_next    = count_reg - sukt_pkg::COUNT_W'(1);
                    do_rem        = 1'b1;
                end
                else
                begin
                    status_next = sukt_pkg::ST_ABSENT;
                end
            end
            sukt_pkg::OP_SEARCH:
            begin
                if (hit)
                begin
                    position_next = sukt_pkg::onehot_index(eq_vec);
                end
                else
                begin
                    status_next = sukt_pkg::ST_ABSENT;
                end
            end
            sukt_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = sukt_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (retire)
            begin
                busy_reg <= 1'b0;
            end

            if (retire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.op;
            key_reg <= req.key;
        end
        if (retire)
        begin
            status_reg    <= status_next;
            position_reg  <= position_next;
            out_count_reg <= count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = position_reg;
    assign rsp.entry_count = out_count_reg;

    assign req_valid       = req.valid;
    assign req_ready       = req.ready;
    assign rsp_valid       = rsp.valid;
    assign rsp_ready       = rsp.ready;
    assign rsp_status      = rsp.status;
    assign rsp_position    = rsp.position;
    assign rsp_entry_count = rsp.entry_count;

endmodule

@@ hw/rtl/sukt_checker.sv @@
// Port-level assertions for the sorted unique key table, bound to the core.
// Depends on sukt_pkg and sorted_unique_key_table_core.
module sukt_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [sukt_pkg::STATUS_W-1:0] rsp_status,
    input  logic [sukt_pkg::SLOT_W-1:0]   rsp_position,
    input  logic [sukt_pkg::COUNT_W-1:0]  rsp_entry_count
);

    // Only one request is in flight, so the word after a taken one must wait.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_position) && $stable(rsp_entry_count))
        else $error("stalled response word changed");

    // Rejected requests carry no slot.
    a_reject_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != sukt_pkg::ST_DONE) |-> rsp_position == '0)
        else $error("rejected request reports a nonzero position");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == sukt_pkg::ST_FULL)
            |-> rsp_entry_count == sukt_pkg::COUNT_W'(sukt_pkg::TABLE_DEPTH))
        else $error("table full reported below capacity");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_entry_count <= sukt_pkg::COUNT_W'(sukt_pkg::TABLE_DEPTH))
        else $error("entry count above capacity");

endmodule

bind sorted_unique_key_table_core sukt_checker u_sukt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp_status      (rsp_status),
    .rsp_position    (rsp_position),
    .rsp_entry_count (rsp_entry_count)
);
